/* rtl/core/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket deframer / unmask core:
// parse phases, result kinds, error causes, opcodes and header length codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    // Parse phase of the frame being received
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_DEAD = 3'd5
    } t_phase;

    // Kind of result item
    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_ERROR = 2'd2
    } t_event;

    // Protocol error cause
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_MASK  = 3'd1,
        ERR_RSV_SET  = 3'd2,
        ERR_BAD_OP   = 3'd3,
        ERR_BAD_CTRL = 3'd4,
        ERR_TOO_BIG  = 3'd5,
        ERR_CONT     = 3'd6
    } t_cause;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Seven-bit length field codes
    localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;

    // Extended length byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Reset value of the payload limit
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16384;

    // One result item, with its valid flag
    typedef struct packed {
        logic       valid;
        t_event     ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        t_cause     cause;
    } t_result;

endpackage : wsd_pkg

`default_nettype wire

/* rtl/core/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker. Holds the per-frame state and
// turns each accepted byte into at most one result item in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic [31:0] i_max_payload,
    output t_result          o_result
);

    // State registers
    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic [2:0]  r_rsv, n_rsv;
    logic [3:0]  r_ext_left, n_ext_left;
    logic [31:0] r_len_lo, n_len_lo;
    logic        r_len_hi_nz, n_len_hi_nz;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_mask_cnt, n_mask_cnt;
    logic [31:0] r_payload, n_payload;
    logic [1:0]  r_mask_pos, n_mask_pos;

    // Decode helpers
    logic [6:0]  len7;
    logic        is_ctrl;
    t_cause      hdr_cause;
    logic [31:0] len_lo;
    logic        len_hi_nz;
    logic        len_known;
    logic        too_big;
    t_cause      len_cause;
    t_cause      cause_now;
    logic        mask_done;
    logic [7:0]  key_byte;

    assign len7    = i_byte[6:0];
    assign is_ctrl = (r_opcode inside {OP_CLOSE, OP_PING, OP_PONG});

    // Check the second header byte against the first
    always_comb begin
        if (!i_byte[7]) begin
            hdr_cause = ERR_NO_MASK;
        end else if (r_rsv != 3'd0) begin
            hdr_cause = ERR_RSV_SET;
        end else if (is_ctrl) begin
            hdr_cause = ((len7 > LEN7_CTRL_MAX) || !r_fin) ? ERR_BAD_CTRL : ERR_NONE;
        end else if (!(r_opcode inside {OP_CONT, OP_TEXT, OP_BINARY})) begin
            hdr_cause = ERR_BAD_OP;
        end else begin
            hdr_cause = ERR_NONE;
        end
    end

    // Assemble the payload length; only the low word and a high-nonzero flag are kept
    always_comb begin
        if (r_phase == PH_HDR1) begin
            len_lo    = {25'd0, len7};
            len_hi_nz = 1'b0;
            len_known = (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64);
        end else begin
            len_lo    = {r_len_lo[23:0], i_byte};
            len_hi_nz = r_len_hi_nz || (r_len_lo[31:24] != 8'd0);
            len_known = (r_ext_left <= 4'd1);
        end
        too_big = len_hi_nz || (len_lo > i_max_payload);
        if (too_big) begin
            len_cause = ERR_TOO_BIG;
        end else if (r_opcode == OP_CONT) begin
            len_cause = ERR_CONT;
        end else begin
            len_cause = ERR_NONE;
        end
    end

    // Pick the error raised by this byte, if any
    always_comb begin
        cause_now = ERR_NONE;
        case (r_phase)
            PH_HDR1: begin
                if (hdr_cause != ERR_NONE) begin
                    cause_now = hdr_cause;
                end else if (len_known) begin
                    cause_now = len_cause;
                end
            end
            PH_EXT: begin
                if (len_known) begin
                    cause_now = len_cause;
                end
            end
            default: cause_now = ERR_NONE;
        endcase
    end

    assign mask_done = (r_mask_cnt == 2'd3);

    // Select the key byte for the current payload position
    always_comb begin
        case (r_mask_pos)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_HDR0: n_phase = PH_HDR1;
                PH_HDR1: begin
                    if (cause_now != ERR_NONE) begin
                        n_phase = PH_DEAD;
                    end else if (!len_known) begin
                        n_phase = PH_EXT;
                    end else begin
                        n_phase = PH_MASK;
                    end
                end
                PH_EXT: begin
                    if (cause_now != ERR_NONE) begin
                        n_phase = PH_DEAD;
                    end else if (len_known) begin
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    if (mask_done) begin
                        n_phase = (r_payload == 32'd0) ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_payload <= 32'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                PH_DEAD: n_phase = PH_DEAD;
                default: n_phase = PH_DEAD;
            endcase
        end
    end

    // Result item for this byte
    always_comb begin
        o_result        = '0;
        o_result.ev     = EV_DATA;
        o_result.cause  = ERR_NONE;
        o_result.opcode = r_opcode;
        o_result.fin    = r_fin;
        if (i_accept) begin
            case (r_phase)
                PH_HDR1, PH_EXT: begin
                    if (cause_now != ERR_NONE) begin
                        o_result.valid = 1'b1;
                        o_result.ev    = EV_ERROR;
                        o_result.cause = cause_now;
                    end
                end
                PH_MASK: begin
                    if (mask_done && (r_payload == 32'd0)) begin
                        o_result.valid = 1'b1;
                        o_result.ev    = EV_EMPTY;
                        o_result.last  = 1'b1;
                    end
                end
                PH_DATA: begin
                    o_result.valid = 1'b1;
                    o_result.ev    = EV_DATA;
                    o_result.data  = i_byte ^ key_byte;
                    o_result.last  = (r_payload <= 32'd1);
                end
                default: o_result.valid = 1'b0;
            endcase
        end
    end

    // Per-frame datapath updates
    always_comb begin
        n_opcode    = r_opcode;
        n_fin       = r_fin;
        n_rsv       = r_rsv;
        n_ext_left  = r_ext_left;
        n_len_lo    = r_len_lo;
        n_len_hi_nz = r_len_hi_nz;
        n_mask_key  = r_mask_key;
        n_mask_cnt  = r_mask_cnt;
        n_payload   = r_payload;
        n_mask_pos  = r_mask_pos;
        if (i_accept) begin
            case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_fin    = i_byte[7];
                    n_rsv    = i_byte[6:4];
                end
                PH_HDR1: begin
                    n_len_lo    = len_lo;
                    n_len_hi_nz = len_hi_nz;
                    n_ext_left  = (len7 == LEN7_EXT64) ? EXT64_BYTES : EXT16_BYTES;
                    if (len_known) begin
                        n_payload  = len_lo;
                        n_mask_cnt = 2'd0;
                        n_len_lo   = 32'd0;
                    end else begin
                        n_len_lo = 32'd0;
                    end
                end
                PH_EXT: begin
                    n_len_lo    = len_lo;
                    n_len_hi_nz = len_hi_nz;
                    n_ext_left  = r_ext_left - 4'd1;
                    if (len_known) begin
                        n_payload  = len_lo;
                        n_mask_cnt = 2'd0;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_mask_cnt = r_mask_cnt + 2'd1;
                    n_mask_pos = 2'd0;
                end
                PH_DATA: begin
                    n_mask_pos = r_mask_pos + 2'd1;
                    n_payload  = r_payload - 32'd1;
                end
                default: n_mask_pos = r_mask_pos;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_mask_cnt  <= 2'd0;
            r_mask_pos  <= 2'd0;
            r_ext_left  <= 4'd0;
            r_len_hi_nz <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mask_cnt  <= n_mask_cnt;
            r_mask_pos  <= n_mask_pos;
            r_ext_left  <= n_ext_left;
            r_len_hi_nz <= n_len_hi_nz;
        end
    end

    // Frame payload registers
    always_ff @(posedge i_clk) begin
        r_opcode   <= n_opcode;
        r_fin      <= n_fin;
        r_rsv      <= n_rsv;
        r_len_lo   <= n_len_lo;
        r_mask_key <= n_mask_key;
        r_payload  <= n_payload;
    end

endmodule : wsd_parser

`default_nettype wire

/* rtl/core/websocket_frame_deframer_unmask_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask_core
// Receive-side WebSocket deframer: parses headers, unmasks payload bytes and
// flags protocol errors, which stick until reset.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ------------------------------------------
//  s_*       in   s_tvalid / s_tready  s_tdata[7:0] rx_byte
//  m_*       out  m_tvalid / m_tready  m_tdata data/opcode/fin/cause,
//                                      m_tuser event, m_tlast last byte
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data max_payload
//
//  One byte per cycle unless stalled. Each byte is parsed in the cycle it is
//  accepted and its result, if any, lands in the output register on that edge,
//  so a result appears in the cycle after its byte. The output register is the
//  only buffer: s_tready drops only while a held result is stalled by m_tready.
//  Reset (synchronous, active low) returns the parser to the first header
//  byte, clears the error state and sets max_payload to 16384.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_unmask_core
    import wsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    // result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] data_byte, [11:8] opcode,
                                         // [12] fin, [15:13] error_cause
    output logic             m_tlast,    // last_byte
    output logic [1:0]       m_tuser,    // [1:0] event_res
    // max_payload register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    logic        s_accept;
    logic [31:0] r_max_payload;
    t_result     parse_res;
    t_result     r_out;
    logic        r_out_valid;

    // Take a request whenever the output register is free or draining
    assign s_tready    = !r_out_valid || m_tready;
    assign s_accept    = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    // Hold the payload limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    wsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_byte        (s_tdata),
        .i_max_payload (r_max_payload),
        .o_result      (parse_res)
    );

    // Output register: load a new result, drop a taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= parse_res.valid;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && parse_res.valid) begin
            r_out <= parse_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.cause, r_out.fin, r_out.opcode, r_out.data};
    assign m_tlast  = r_out.last;
    assign m_tuser  = r_out.ev;

    // After an error is delivered nothing else comes out
    a_dead_after_error : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && (m_tuser == EV_ERROR)) |=> !m_tvalid)
        else $error("result delivered after a protocol error");

    // Error results carry a cause and no last mark
    a_error_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == EV_ERROR)) |-> (!m_tlast && (m_tdata[15:13] != ERR_NONE)))
        else $error("error result with bad fields");

    // Empty-frame events are last, with no data and no cause
    a_empty_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == EV_EMPTY))
            |-> (m_tlast && (m_tdata[7:0] == 8'd0) && (m_tdata[15:13] == ERR_NONE)))
        else $error("empty-frame event with bad fields");

endmodule : websocket_frame_deframer_unmask_core

`default_nettype wire

/* verif/websocket_frame_deframer_unmask_checker.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask_checker
// Watches the byte, result and max_payload channels of the deframer, keeps
// its own copy of the parser state, predicts the result of every accepted
// byte and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_unmask_checker
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_event     ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        t_cause     cause;
    } t_rx_result;

    t_rx_result  expected_results[$];
    int          mismatch_count = 0;

    // Shadow of the parser
    logic [31:0] payload_limit;
    t_phase      phase;
    logic [3:0]  hdr_opcode;
    logic        hdr_fin;
    logic [3:0]  ext_left;
    logic [63:0] len_acc;
    logic [31:0] key_reg;
    logic [2:0]  key_count;
    logic [31:0] bytes_left;
    logic [1:0]  key_idx;

    function automatic void queue_result(t_event ev, logic [7:0] data, logic last,
                                         t_cause cause);
        t_rx_result r;
        r.ev     = ev;
        r.data   = data;
        r.opcode = hdr_opcode;
        r.fin    = hdr_fin;
        r.last   = last;
        r.cause  = cause;
        expected_results.push_back(r);
    endfunction

    // Any error kills the parser until reset
    function automatic void raise_error(t_cause cause);
        phase = PH_DEAD;
        queue_result(EV_ERROR, 8'h00, 1'b0, cause);
    endfunction

    // Full length is in: check it against the limit, then collect the key
    function automatic void close_length();
        if (len_acc > {32'd0, payload_limit}) begin
            raise_error(ERR_TOO_BIG);
        end else if (hdr_opcode == OP_CONT) begin
            raise_error(ERR_CONT);
        end else begin
            bytes_left = len_acc[31:0];
            key_count  = 3'd0;
            key_reg    = 32'd0;
            phase      = PH_MASK;
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] rx);
        logic [6:0] len7;
        logic       ctrl;
        logic       last;
        len7 = rx[6:0];
        ctrl = (hdr_opcode == OP_CLOSE) || (hdr_opcode == OP_PING) ||
               (hdr_opcode == OP_PONG);
        case (phase)
            PH_HDR0: begin
                // Keep the whole first byte so RSV can be checked next
                len_acc    = {56'd0, rx};
                hdr_opcode = rx[3:0];
                hdr_fin    = rx[7];
                phase      = PH_HDR1;
            end
            PH_HDR1: begin
                if (!rx[7]) begin
                    raise_error(ERR_NO_MASK);
                end else if (len_acc[6:4] != 3'd0) begin
                    raise_error(ERR_RSV_SET);
                end else if (ctrl && (len7 > LEN7_CTRL_MAX || !hdr_fin)) begin
                    raise_error(ERR_BAD_CTRL);
                end else if (!ctrl && hdr_opcode > OP_BINARY) begin
                    raise_error(ERR_BAD_OP);
                end else if (len7 == LEN7_EXT16) begin
                    len_acc  = 64'd0;
                    ext_left = EXT16_BYTES;
                    phase    = PH_EXT;
                end else if (len7 == LEN7_EXT64) begin
                    len_acc  = 64'd0;
                    ext_left = EXT64_BYTES;
                    phase    = PH_EXT;
                end else begin
                    len_acc = {57'd0, len7};
                    close_length();
                end
            end
            PH_EXT: begin
                // Big-endian: shift in from the bottom
                len_acc = {len_acc[55:0], rx};
                if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0) close_length();
            end
            PH_MASK: begin
                key_reg   = {key_reg[23:0], rx};
                key_count = key_count + 3'd1;
                if (key_count == 3'd4) begin
                    key_idx = 2'd0;
                    if (bytes_left == 32'd0) begin
                        phase = PH_HDR0;
                        queue_result(EV_EMPTY, 8'h00, 1'b1, ERR_NONE);
                    end else begin
                        phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                // First key byte is the most significant one
                last = (bytes_left <= 32'd1);
                queue_result(EV_DATA, rx ^ key_reg[8*(3-key_idx) +: 8], last, ERR_NONE);
                key_idx = key_idx + 2'd1;
                if (bytes_left != 32'd0) bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0) phase = PH_HDR0;
            end
            default: phase = PH_DEAD;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_rx_result got;
        t_rx_result want;
        if (!i_rst_n) begin
            payload_limit = MAX_PAYLOAD_RST;
            phase         = PH_HDR0;
            hdr_opcode    = 4'd0;
            hdr_fin       = 1'b0;
            ext_left      = 4'd0;
            len_acc       = 64'd0;
            key_reg       = 32'd0;
            key_count     = 3'd0;
            bytes_left    = 32'd0;
            key_idx       = 2'd0;
            expected_results.delete();
        end else begin
            // A byte taken on the same edge as a limit write still sees the old limit
            if (i_s_tvalid && i_s_tready) deframe_byte(i_s_tdata);
            if (i_cfg_valid && i_cfg_ready) payload_limit = i_cfg_data;

            // Compare an accepted result with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.ev     = t_event'(i_m_tuser);
                got.data   = i_m_tdata[7:0];
                got.opcode = i_m_tdata[11:8];
                got.fin    = i_m_tdata[12];
                got.last   = i_m_tlast;
                got.cause  = t_cause'(i_m_tdata[15:13]);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result ev=%0d data=%02h op=%0d cause=%0d",
                                 $realtime, got.ev, got.data, got.opcode, got.cause);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected ev=%0d data=%02h op=%0d fin=%b last=%b cause=%0d",
                                     want.ev, want.data, want.opcode, want.fin, want.last,
                                     want.cause);
                            $display("  actual   ev=%0d data=%02h op=%0d fin=%b last=%b cause=%0d",
                                     got.ev, got.data, got.opcode, got.fin, got.last,
                                     got.cause);
                        end
                    end
                end
            end
        end
        o_outstanding <= expected_results.size();
        o_mismatches  <= mismatch_count;
    end

endmodule : websocket_frame_deframer_unmask_checker

/* verif/websocket_frame_deframer_unmask_core_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask_core_tb
// Drives masked WebSocket frames into the deframer under several payload
// limits and idle patterns; a checker beside the block predicts and compares
// every result. Since errors stick until reset, the stream ends with a single
// broken frame of a randomly chosen kind followed by trailing noise.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_unmask_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [7:0] MASK_BIT    = 8'h80;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = 32'd0;

    int          mismatches;
    int          outstanding;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycles        = 0;
    int          n_bytes       = 0;
    int          n_frames      = 0;
    logic [31:0] mid_limit;
    t_cause      final_cause;

    websocket_frame_deframer_unmask_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    websocket_frame_deframer_unmask_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] hdr(logic fin, logic [3:0] op);
        return {fin, 3'b000, op};
    endfunction

    // Offer one request, with random gaps in front of it
    task automatic send_byte(logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n_bytes++;
    endtask

    // Hold off until every predicted result has left the block
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Header, length, key, then body_len payload bytes
    task automatic send_frame(logic [7:0] hdr0, logic mask_on, logic [63:0] len,
                              t_len_form form, logic [31:0] key, bit alt_fill,
                              int unsigned body_len);
        send_byte(hdr0);
        case (form)
            LEN_SHORT: begin
                send_byte({mask_on, len[6:0]});
            end
            LEN_EXT16: begin
                send_byte({mask_on, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({mask_on, LEN7_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        for (int unsigned i = 0; i < body_len; i++)
            send_byte(alt_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
        n_frames++;
    endtask

    // Well-formed frame whose length stays within the limit
    task automatic random_frame(logic [31:0] limit);
        logic [3:0]  op;
        logic        fin;
        int unsigned len;
        t_len_form   form;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 40)      op = OP_TEXT;
        else if (pick < 70) op = OP_BINARY;
        else if (pick < 80) op = OP_CLOSE;
        else if (pick < 90) op = OP_PING;
        else                op = OP_PONG;
        pick = $urandom_range(99);
        if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
            fin  = 1'b1;
            len  = (pick < 80) ? $urandom_range(16) : $urandom_range(125);
            form = LEN_SHORT;
        end else begin
            fin = 1'($urandom_range(1));
            if (pick < 70)      len = $urandom_range(16);
            else if (pick < 90) len = $urandom_range(125, 17);
            else                len = $urandom_range(300, 126);
            pick = $urandom_range(99);
            if (len > 125)      form = (pick < 70) ? LEN_EXT16 : LEN_EXT64;
            else if (pick < 70) form = LEN_SHORT;
            else if (pick < 90) form = LEN_EXT16;
            else                form = LEN_EXT64;
        end
        if (len > limit) len = limit;
        send_frame(hdr(fin, op), 1'b1, 64'(len), form, $urandom, 1'b0, len);
        if ($urandom_range(11) == 0) drain();
    endtask

    task automatic random_phase(logic [31:0] limit, int target);
        int start;
        start = n_bytes;
        while (n_bytes - start < target) random_frame(limit);
    endtask

    // One broken frame of the chosen kind; the parser stays dead afterwards
    task automatic break_stream(t_cause cause);
        logic [3:0]  op;
        logic [63:0] len;
        case (cause)
            ERR_NO_MASK: begin
                send_frame(hdr(1'b1, OP_TEXT), 1'b0, 64'($urandom_range(125)), LEN_SHORT,
                           $urandom, 1'b0, 3);
            end
            ERR_RSV_SET: begin
                send_frame({1'($urandom_range(1)), 3'($urandom_range(7, 1)), 4'($urandom)},
                           1'b1, 64'($urandom_range(125)), LEN_SHORT, $urandom, 1'b0, 3);
            end
            ERR_BAD_OP: begin
                op = $urandom_range(1) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
                send_frame(hdr(1'($urandom_range(1)), op), 1'b1, 64'($urandom_range(125)),
                           LEN_SHORT, $urandom, 1'b0, 3);
            end
            ERR_BAD_CTRL: begin
                op = ($urandom_range(2) == 0) ? OP_CLOSE :
                     ($urandom_range(1) ? OP_PING : OP_PONG);
                if ($urandom_range(1))
                    send_frame(hdr(1'b0, op), 1'b1, 64'($urandom_range(125)), LEN_SHORT,
                               $urandom, 1'b0, 3);
                else
                    send_frame(hdr(1'b1, op), 1'b1, 64'($urandom_range(127, 126)),
                               LEN_SHORT, $urandom, 1'b0, 3);
            end
            ERR_TOO_BIG: begin
                if ($urandom_range(1)) begin
                    send_frame(hdr(1'b1, OP_BINARY), 1'b1, 64'($urandom_range(65535, 16385)),
                               LEN_EXT16, $urandom, 1'b0, 3);
                end else begin
                    len = {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)};
                    send_frame(hdr(1'b1, OP_TEXT), 1'b1, len, LEN_EXT64, $urandom, 1'b0, 3);
                end
            end
            default: begin
                send_frame(hdr(1'($urandom_range(1)), OP_CONT), 1'b1,
                           64'($urandom_range(125)),
                           $urandom_range(1) ? LEN_SHORT : LEN_EXT16, $urandom, 1'b0, 3);
            end
        endcase
        // Trailing noise must be swallowed silently
        repeat (12) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No payload limit; sender light, receiver heavy idling
        send_idle_pct = 33;
        recv_idle_pct = 62;
        write_limit(32'hFFFF_FFFF);
        send_frame(hdr(1'b1, OP_TEXT),   1'b1, 64'd0,   LEN_SHORT, 32'h0000_0000, 1'b0, 0);
        send_frame(hdr(1'b0, OP_BINARY), 1'b1, 64'd1,   LEN_SHORT, 32'hFFFF_FFFF, 1'b1, 1);
        send_frame(hdr(1'b1, OP_TEXT),   1'b1, 64'd6,   LEN_SHORT, 32'h0000_0000, 1'b1, 6);
        send_frame(hdr(1'b1, OP_CLOSE),  1'b1, 64'd2,   LEN_SHORT, $urandom,      1'b0, 2);
        send_frame(hdr(1'b1, OP_PING),   1'b1, 64'd0,   LEN_SHORT, $urandom,      1'b0, 0);
        send_frame(hdr(1'b1, OP_PONG),   1'b1, 64'd125, LEN_SHORT, $urandom,      1'b0, 125);
        send_frame(hdr(1'b1, OP_TEXT),   1'b1, 64'd3,   LEN_EXT16, $urandom,      1'b0, 3);
        send_frame(hdr(1'b0, OP_BINARY), 1'b1, 64'd2,   LEN_EXT64, $urandom,      1'b0, 2);
        send_frame(hdr(1'b1, OP_TEXT),   1'b1, 64'd0,   LEN_EXT64, $urandom,      1'b0, 0);
        random_phase(32'hFFFF_FFFF, 40);
        drain();

        // Zero limit: only empty frames pass; roles of the two sides swapped
        send_idle_pct = 62;
        recv_idle_pct = 33;
        write_limit(32'd0);
        repeat (8) random_frame(32'd0);
        drain();

        // Small limit, with one frame right at it
        mid_limit = $urandom_range(60, 20);
        write_limit(mid_limit);
        send_frame(hdr(1'b1, OP_BINARY), 1'b1, 64'(mid_limit), LEN_EXT16, $urandom, 1'b0,
                   mid_limit);
        random_phase(mid_limit, 40);
        drain();

        // Reset-value limit, no idling on either side, then end on an error
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(MAX_PAYLOAD_RST);
        random_phase(MAX_PAYLOAD_RST, 40);
        final_cause = t_cause'($urandom_range(int'(ERR_CONT), int'(ERR_NO_MASK)));
        break_stream(final_cause);
        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d frames under limits all-ones, 0, %0d and %0d.",
                 n_bytes, n_frames, mid_limit, MAX_PAYLOAD_RST);
        $display("Stream closed by a broken frame (%s) and trailing noise; %0d mismatches.",
                 final_cause.name(), mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : websocket_frame_deframer_unmask_core_tb
